[rtl/core/fsvd_pkg.sv]
// Shared types, constants and handshake structs of the frame sequencer.
`default_nettype none
package fsvd_pkg;

    localparam int MAX_FRAMES   = 16;
    localparam int MAX_ADVANCES = 64;

    localparam int FRAME_W = 4;
    localparam int COUNT_W = 5;
    localparam int MODE_W  = 3;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int STEP_W  = $clog2(MAX_ADVANCES + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [DELAY_W-1:0] RESET_DELAY = DELAY_W'(200);

    typedef enum logic [1:0] {
        OP_UPDATE   = 2'd0,
        OP_WRITE    = 2'd1,
        OP_SET_PLAY = 2'd2,
        OP_NONE     = 2'd3
    } fsvd_op_t;

    localparam logic [MODE_W-1:0] MODE_LOOP_FWD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP_BWD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ONCE_FWD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ONCE_BWD  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PING_PONG = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE   = 2'd1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [TIME_W-1:0]  now_ms;
        logic [FRAME_W-1:0] frame_index;
        logic [DELAY_W-1:0] delay_ms;
        logic               play_enable;
        logic               go_backward;
    } fsvd_in_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               playing;
        logic               backward;
        logic               write_rejected;
    } fsvd_out_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic advance;
        logic publish;
    } fsvd_cmd_t;

    typedef struct packed {
        logic run_loop;
        logic loop_end;
        logic out_free;
    } fsvd_status_t;

endpackage
`default_nettype wire

[rtl/core/frame_sequencer_variable_delay_core.sv]
// Top level of the frame sequencer with per-frame delays.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_ready   in_data   (fsvd_in_t)
//  out       output     out_valid / out_ready out_data  (fsvd_out_t)
//  cfg       input      cfg_we                cfg_index, cfg_data
//
// One item at a time. A delay write, set-play or idle update passes through accept,
// execute and publish, and the result register loads at publish. A playing update
// of two or more frames adds loop steps before publish: one table read and compare
// per frame advance (at most MAX_ADVANCES), plus one closing compare unless the last
// advance ends a one-shot run.
// Reset loads frame count 1, loop-forward mode, frame 0 stopped and delay 200 in
// entry zero; all other entries clear. The result register frees the loop: a held
// output stalls only the finish of the next item, and input ready drops while an
// item is in flight.
`default_nettype none
module frame_sequencer_variable_delay_core
    import fsvd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire fsvd_in_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output fsvd_out_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    fsvd_cmd_t    cmd;
    fsvd_status_t status;

    // sequence capture, execute, step loop and publish
    fsvd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold play state, time reference, delay table and the result register
    fsvd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

[rtl/core/fsvd_ctrl.sv]
// Control state machine of the frame sequencer.
`default_nettype none
module fsvd_ctrl
    import fsvd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire fsvd_status_t status,
    output fsvd_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOOP = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = status.run_loop ? S_LOOP : S_DONE;
            end
            S_LOOP:
            begin
                cmd.advance = 1'b1;
                if (status.loop_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output slot frees up
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/fsvd_datapath.sv]
// Datapath of the frame sequencer: state, delay table, stepping and output register.
`default_nettype none
module fsvd_datapath
    import fsvd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire fsvd_in_t              in_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire fsvd_cmd_t             cmd,
    output fsvd_status_t               status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output fsvd_out_t                  out_data
);

    fsvd_in_t           item_reg;
    logic [FRAME_W-1:0] frame_reg,    frame_next;
    logic               playing_reg,  playing_next;
    logic               backward_reg, backward_next;
    logic [TIME_W-1:0]  tref_reg,     tref_next;
    logic [TIME_W-1:0]  diff_reg,     diff_next;
    logic [STEP_W-1:0]  steps_reg,    steps_next;
    logic               rej_reg,      rej_next;
    logic [COUNT_W-1:0] count_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic               out_valid_reg;
    fsvd_out_t          out_data_reg;
    logic [DELAY_W-1:0] table_reg [MAX_FRAMES];

    logic [COUNT_W-1:0] used_n;
    logic [MODE_W-1:0]  mode_eff;
    logic [DELAY_W-1:0] cur_delay;
    logic [TIME_W-1:0]  delay_ext;
    logic               go;
    logic               past_top;
    logic               past_bottom;
    logic [FRAME_W-1:0] step_frame;
    logic               step_back;
    logic               step_play;
    logic [FRAME_W-1:0] last_frame;
    logic               write_hit;

    assign used_n     = (count_reg > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : count_reg;
    assign last_frame = FRAME_W'(used_n - 1'b1);
    assign mode_eff   = (mode_reg > MODE_PING_PONG) ? MODE_LOOP_FWD : mode_reg;
    assign cur_delay  = (table_reg[frame_reg] == '0) ? DELAY_W'(1) : table_reg[frame_reg];
    assign delay_ext  = TIME_W'(cur_delay);
    assign go         = (diff_reg >= delay_ext) && (steps_reg != STEP_W'(MAX_ADVANCES));

    // one frame in the current direction, then apply the mode at the ends
    always_comb
    begin
        past_top    = 1'b0;
        past_bottom = 1'b0;
        step_frame  = frame_reg;
        step_back   = backward_reg;
        step_play   = playing_reg;
        if (backward_reg)
        begin
            if (frame_reg == '0)
                past_bottom = 1'b1;
            else
                step_frame = frame_reg - 1'b1;
        end
        else
        begin
            if ((COUNT_W'(frame_reg) + 1'b1) >= used_n)
                past_top = 1'b1;
            else
                step_frame = frame_reg + 1'b1;
        end
        if (mode_eff == MODE_PING_PONG)
        begin
            if (past_top)
            begin
                step_frame = FRAME_W'(used_n - COUNT_W'(2));
                step_back  = 1'b1;
            end
            else if (past_bottom)
            begin
                step_frame = FRAME_W'(1);
                step_back  = 1'b0;
            end
        end
        else
        begin
            if (past_top)
                step_frame = '0;
            else if (past_bottom)
                step_frame = last_frame;
            if ((mode_eff == MODE_ONCE_FWD || mode_eff == MODE_ONCE_BWD)
                && (past_top || past_bottom))
                step_play = 1'b0;
        end
    end

    assign status.run_loop = (item_reg.opcode == OP_UPDATE) && (used_n >= COUNT_W'(2))
                             && playing_reg;
    assign status.loop_end = !go || !step_play;
    assign status.out_free = !out_valid_reg || out_ready;

    assign write_hit = cmd.execute && (item_reg.opcode == OP_WRITE)
                       && (COUNT_W'(item_reg.frame_index) < used_n);

    always_comb
    begin
        frame_next    = frame_reg;
        playing_next  = playing_reg;
        backward_next = backward_reg;
        tref_next     = tref_reg;
        diff_next     = diff_reg;
        steps_next    = steps_reg;
        rej_next      = rej_reg;
        if (cmd.execute)
        begin
            rej_next = 1'b0;
            case (item_reg.opcode)
                OP_UPDATE:
                begin
                    if (!status.run_loop)
                    begin
                        tref_next = item_reg.now_ms;
                    end
                    else
                    begin
                        if (COUNT_W'(frame_reg) >= used_n)
                            frame_next = last_frame;
                        diff_next  = item_reg.now_ms - tref_reg;
                        steps_next = '0;
                    end
                end
                OP_WRITE:
                begin
                    rej_next = !write_hit;
                end
                OP_SET_PLAY:
                begin
                    if (COUNT_W'(item_reg.frame_index) >= used_n)
                        frame_next = (used_n == '0) ? '0 : last_frame;
                    else
                        frame_next = item_reg.frame_index;
                    playing_next  = item_reg.play_enable;
                    backward_next = item_reg.go_backward;
                    tref_next     = item_reg.now_ms;
                end
                default:
                begin
                    rej_next = 1'b0;
                end
            endcase
        end
        else if (cmd.advance)
        begin
            if (go)
            begin
                frame_next    = step_frame;
                backward_next = step_back;
                playing_next  = step_play;
                tref_next     = tref_reg + delay_ext;
                diff_next     = diff_reg - delay_ext;
                steps_next    = steps_reg + 1'b1;
            end
            else if ((steps_reg == STEP_W'(MAX_ADVANCES)) && playing_reg)
            begin
                // advance bound hit while still playing: resync to now
                tref_next = item_reg.now_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        diff_reg  <= diff_next;
        steps_reg <= steps_next;
        if (cmd.publish)
        begin
            out_data_reg.frame          <= frame_reg;
            out_data_reg.playing        <= playing_reg;
            out_data_reg.backward       <= backward_reg;
            out_data_reg.write_rejected <= rej_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            playing_reg   <= 1'b0;
            backward_reg  <= 1'b0;
            tref_reg      <= '0;
            rej_reg       <= 1'b0;
            count_reg     <= COUNT_W'(1);
            mode_reg      <= MODE_LOOP_FWD;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                table_reg[i] <= (i == 0) ? RESET_DELAY : '0;
            end
        end
        else
        begin
            frame_reg    <= frame_next;
            playing_reg  <= playing_next;
            backward_reg <= backward_next;
            tref_reg     <= tref_next;
            rej_reg      <= rej_next;
            if (cfg_we && cfg_index == CFG_FRAME_COUNT)
                count_reg <= cfg_data[COUNT_W-1:0];
            if (cfg_we && cfg_index == CFG_PLAY_MODE)
                mode_reg <= cfg_data[MODE_W-1:0];
            if (write_hit)
                table_reg[item_reg.frame_index] <= item_reg.delay_ms;
            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire
